FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies; pulled in with `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge while out of reset
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true while out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK_RST(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: hw/rtl/pzr_pkg.sv
// types, constants and helper functions of the palette zero-run decoder
// no dependencies; used through scoped names by pzr_front, pzr_back and the top level
`default_nettype none

package pzr_pkg;

  localparam int unsigned MAX_PIXELS    = 65536;
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned COLOR_W       = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] ALPHA_OPAQUE  = 32'hFF00_0000;
  localparam logic [23:0] KEY_MAGENTA   = 24'hFF_00FF;
  localparam logic [15:0] START_SAT     = 16'hFFFF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_TRANSP = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_SWAP   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [7:0]  run_length;
    logic [15:0] start_index;
    logic        end_of_image;
    logic        index_overflow;
  } out_item_t;

  // run descriptor handed from the front to the back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  run_length;
    logic [15:0] start_index;
    logic        end_of_image;
    logic        index_overflow;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic [31:0] swap_red_blue(input logic [31:0] c);
    swap_red_blue = ALPHA_OPAQUE | {8'h00, c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic logic [31:0] resolve_color(input cmd_kind_e kind,
                                                input logic [31:0] c);
    logic [31:0] res;
    res = '0;
    unique case (kind)
      CMD_RAW:  res = (c[23:0] == KEY_MAGENTA) ? 32'h0 : (ALPHA_OPAQUE | c);
      CMD_SWAP: res = swap_red_blue(c);
      default:  res = '0;
    endcase
    resolve_color = res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pzr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pzr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pzr_front.sv
// front of the decoder: accepts items, keeps mode/zero/position state, drives palette ports
// depends on pzr_pkg
`default_nettype none

module pzr_front #(
  parameter int unsigned MAX_PIXELS = pzr_pkg::MAX_PIXELS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire pzr_pkg::in_item_t in_item_i,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  output      logic              pal_we_o,
  output      logic [7:0]        pal_waddr_o,
  output      logic [31:0]       pal_wdata_o,
  output      logic [7:0]        pal_raddr_o,
  output      logic              cmd_valid_o,
  output      pzr_pkg::cmd_t     cmd_o
);

  localparam int unsigned PosW = $clog2(MAX_PIXELS + 1);

  logic            mode_q;
  logic            zp_q, zp_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            cmd_valid_q, cmd_valid_d;
  pzr_pkg::cmd_t   cmd_q, cmd_d;

  logic        is_data;
  logic        emit;
  logic [31:0] run_end;
  logic        over;

  assign is_data = accept_i && (in_item_i.operation == pzr_pkg::OP_DATA);

  always_comb begin
    zp_d    = zp_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    emit    = 1'b0;
    run_end = '0;
    over    = 1'b0;
    cmd_d.kind           = pzr_pkg::CMD_TRANSP;
    cmd_d.run_length     = 8'd1;
    cmd_d.start_index    = (32'(pos_q) > 32'(pzr_pkg::START_SAT)) ?
                           pzr_pkg::START_SAT : 16'(pos_q);
    cmd_d.end_of_image   = in_item_i.last_byte;
    cmd_d.index_overflow = ovf_q;
    if (is_data) begin
      priority if (!mode_q) begin
        zp_d       = 1'b0;
        emit       = 1'b1;
        cmd_d.kind = pzr_pkg::CMD_RAW;
      end else if (zp_q) begin
        // count byte after a zero marker
        zp_d             = 1'b0;
        cmd_d.run_length = in_item_i.data_byte;
        emit             = (in_item_i.data_byte != 8'd0) || in_item_i.last_byte;
      end else if (in_item_i.data_byte == 8'd0) begin
        if (in_item_i.last_byte) begin
          emit = 1'b1;
        end else begin
          zp_d = 1'b1;
        end
      end else begin
        emit       = 1'b1;
        cmd_d.kind = pzr_pkg::CMD_SWAP;
      end
      if (emit) begin
        run_end = 32'(pos_q) + 32'(cmd_d.run_length);
        over    = run_end > 32'(MAX_PIXELS);
        if (over) begin
          pos_d = PosW'(MAX_PIXELS);
          ovf_d = 1'b1;
        end else begin
          pos_d = PosW'(run_end);
        end
        cmd_d.index_overflow = ovf_q | over;
        if (in_item_i.last_byte) begin
          zp_d  = 1'b0;
          pos_d = '0;
          ovf_d = 1'b0;
        end
      end
    end
    cmd_valid_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      zp_q        <= 1'b0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      cmd_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      zp_q        <= zp_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign pal_we_o    = accept_i && (in_item_i.operation == pzr_pkg::OP_WRITE);
  assign pal_waddr_o = in_item_i.entry_index;
  assign pal_wdata_o = in_item_i.entry_color;
  assign pal_raddr_o = in_item_i.data_byte;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pzr_back.sv
// back of the decoder: resolves run colors and queues results for the reader
// depends on pzr_pkg
`default_nettype none

module pzr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire pzr_pkg::cmd_t      cmd_i,
  input  wire logic [31:0]        pal_rdata_i,
  input  wire logic               pop_i,
  output      logic               empty_o,
  output      pzr_pkg::out_item_t out_item_o,
  output      pzr_pkg::q_status_t status_o
);

  localparam int unsigned Depth = pzr_pkg::QUEUE_DEPTH;

  pzr_pkg::out_item_t                 mem_q [Depth];
  logic [pzr_pkg::QPTR_W-1:0]         wptr_q, wptr_d;
  logic [pzr_pkg::QPTR_W-1:0]         rptr_q, rptr_d;
  logic [pzr_pkg::QCNT_W-1:0]         count_q, count_d;
  pzr_pkg::out_item_t                 item_w;
  logic                               do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    item_w.pixel_color    = pzr_pkg::resolve_color(cmd_i.kind, pal_rdata_i);
    item_w.run_length     = cmd_i.run_length;
    item_w.start_index    = cmd_i.start_index;
    item_w.end_of_image   = cmd_i.end_of_image;
    item_w.index_overflow = cmd_i.index_overflow;
  end

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (cmd_valid_i) begin
      wptr_d = (32'(wptr_q) == Depth - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == Depth - 1) ? '0 : rptr_q + 1'b1;
    end
    unique case ({cmd_valid_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      mem_q[wptr_q] <= item_w;
    end
  end

  // room is reserved for the run still waiting on its palette read
  assign status_o.full  = (32'(count_q) + 32'(cmd_valid_i)) >= Depth;
  assign status_o.count = count_q;
  assign empty_o        = (count_q == '0);
  assign out_item_o     = mem_q[rptr_q];

endmodule

`default_nettype wire

FILE: hw/rtl/palette_zero_run_decoder.sv
// palette zero-run decoder, top level; depends on pzr_pkg, pzr_front, pzr_ram, pzr_back
// path: the run register and the registered palette read are filled together, then the
// queue write stores the result, and only from there can the reader pop it
// throughput: one item per cycle; full rises only when the 4-entry result queue backs up
// reset: clears mode (to compressed), zero marker, position, overflow and the queue
// the palette ram is not cleared by reset and reads undefined until written
`default_nettype none
`include "assert_macros.svh"

module palette_zero_run_decoder #(
  parameter int unsigned MAX_PIXELS = pzr_pkg::MAX_PIXELS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output      logic               full,
  input  wire pzr_pkg::in_item_t  in_item_i,
  output      logic               empty,
  input  wire logic               pop,
  output      pzr_pkg::out_item_t out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  logic               accept;
  logic               pal_we;
  logic [7:0]         pal_waddr;
  logic [31:0]        pal_wdata;
  logic [7:0]         pal_raddr;
  logic [31:0]        pal_rdata;
  logic               cmd_valid;
  pzr_pkg::cmd_t      cmd;
  pzr_pkg::q_status_t q_status;

  assign accept = push && !q_status.full;
  assign full   = q_status.full;

  pzr_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pal_we_o    (pal_we),
    .pal_waddr_o (pal_waddr),
    .pal_wdata_o (pal_wdata),
    .pal_raddr_o (pal_raddr),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  pzr_ram #(
    .WIDTH (pzr_pkg::COLOR_W),
    .DEPTH (pzr_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  pzr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pal_rdata_i (pal_rdata),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o),
    .status_o    (q_status)
  );

  `ASSERT_CLK_RST(a_write_no_run, clk_i, rst_ni,
    (accept && in_item_i.operation == pzr_pkg::OP_WRITE) |=> !cmd_valid,
    "palette write produced a run")
  `ASSERT_NEVER(a_queue_overrun, clk_i, rst_ni,
    cmd_valid && (32'(q_status.count) >= pzr_pkg::QUEUE_DEPTH),
    "run arrived with the result queue full")
  `ASSERT_CLK_RST(a_run_visible, clk_i, rst_ni,
    cmd_valid |=> !empty,
    "queued run not visible on the result side")

endmodule

`default_nettype wire

FILE: dv/palette_zero_run_decoder_tb.sv
`timescale 1ns / 100ps
// testbench of palette_zero_run_decoder: directed table, then random images under three idle mixes
// every accepted item goes through an in-bench decoder; depends on pzr_pkg and the rtl only
module palette_zero_run_decoder_tb;

  localparam int   CLK_HALF      = 5;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   SETTLE_CYCLES = 6;
  localparam int   PHASE_ITEMS   = 100;
  localparam logic MODE_RAW      = 1'b0;
  localparam logic MODE_ZRUN     = 1'b1;

  typedef enum logic {
    ROW_ITEM,
    ROW_MODE
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    pzr_pkg::in_item_t  item;
    bit                 typed;
    pzr_pkg::out_item_t run;
    logic               mode;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  pzr_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  pzr_pkg::out_item_t out_item;
  logic               cfg_we;
  logic               cfg_wdata;

  // typed expectation that travels with the item being offered
  bit                 typed_due;
  pzr_pkg::out_item_t typed_run;

  // decoder state mirrored in the bench
  logic [31:0] pal_mem [256];
  bit          zero_marker;
  bit          pix_ovf;
  int unsigned pix_pos;
  logic        zrun_mode;

  pzr_pkg::out_item_t run_q [$];
  dir_row_t           dir_rows [$];

  int send_idle;
  int recv_idle;
  bit hold_req;
  int quiet_cycles;
  int n_errors;
  int n_items;
  int n_runs;
  int n_eoi;
  int n_ovf;
  int n_mode_writes;

  palette_zero_run_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // position update shared by every run; clears the image state on the last byte
  function automatic pzr_pkg::out_item_t close_run(logic [31:0] col, logic [7:0] len, bit eoi);
    pzr_pkg::out_item_t r;
    r.pixel_color = col;
    r.run_length  = len;
    r.start_index = (pix_pos > 32'hFFFF) ? 16'hFFFF : pix_pos[15:0];
    if (pix_pos + len > pzr_pkg::MAX_PIXELS) begin
      pix_pos = pzr_pkg::MAX_PIXELS;
      pix_ovf = 1'b1;
    end else begin
      pix_pos = pix_pos + len;
    end
    r.end_of_image   = eoi;
    r.index_overflow = pix_ovf;
    if (eoi) begin
      zero_marker = 1'b0;
      pix_pos     = 0;
      pix_ovf     = 1'b0;
    end
    return r;
  endfunction

  function automatic bit decode_item(pzr_pkg::in_item_t it, output pzr_pkg::out_item_t r);
    logic [31:0] c;
    r = '0;
    if (it.operation == pzr_pkg::OP_WRITE) begin
      pal_mem[it.entry_index] = it.entry_color;
      return 1'b0;
    end
    if (zrun_mode == MODE_RAW) begin
      // a pending zero marker is simply dropped
      zero_marker = 1'b0;
      c = pal_mem[it.data_byte];
      c = (c[23:0] == pzr_pkg::KEY_MAGENTA) ? 32'h0 : (c | pzr_pkg::ALPHA_OPAQUE);
      r = close_run(c, 8'd1, it.last_byte);
      return 1'b1;
    end
    if (zero_marker) begin
      zero_marker = 1'b0;
      if (it.data_byte == 8'h00 && !it.last_byte) return 1'b0;
      r = close_run(32'h0, it.data_byte, it.last_byte);
      return 1'b1;
    end
    if (it.data_byte == 8'h00) begin
      if (!it.last_byte) begin
        zero_marker = 1'b1;
        return 1'b0;
      end
      r = close_run(32'h0, 8'd1, 1'b1);
      return 1'b1;
    end
    c = pal_mem[it.data_byte];
    r = close_run({8'hFF, c[7:0], c[15:8], c[23:16]}, 8'd1, it.last_byte);
    return 1'b1;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // monitor: check results, then predict from the item taken at the same edge
  always @(posedge clk) begin
    pzr_pkg::out_item_t want;
    pzr_pkg::out_item_t calc;
    bit                 made;
    if (rst_n) begin
      quiet_cycles++;
      if (pop && !empty) begin
        quiet_cycles = 0;
        n_runs++;
        if (out_item.end_of_image) n_eoi++;
        if (out_item.index_overflow) n_ovf++;
        if (run_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected run, expected none, got %h", $time, out_item);
        end else begin
          want = run_q.pop_front();
          cmp_field("pixel_color", want.pixel_color, out_item.pixel_color);
          cmp_field("run_length", 32'(want.run_length), 32'(out_item.run_length));
          cmp_field("start_index", 32'(want.start_index), 32'(out_item.start_index));
          cmp_field("end_of_image", 32'(want.end_of_image), 32'(out_item.end_of_image));
          cmp_field("index_overflow", 32'(want.index_overflow),
                    32'(out_item.index_overflow));
        end
      end
      if (push && !full) begin
        quiet_cycles = 0;
        n_items++;
        made = decode_item(in_item, calc);
        if (made) run_q.push_back(typed_due ? typed_run : calc);
      end
      if (cfg_we) begin
        quiet_cycles = 0;
        n_mode_writes++;
        zrun_mode = cfg_wdata;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random pops, plus one long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  function automatic logic [31:0] rand_color();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 5) == 0) c[23:0] = pzr_pkg::KEY_MAGENTA;
    return c;
  endfunction

  function automatic pzr_pkg::in_item_t write_item(logic [7:0] idx, logic [31:0] col);
    pzr_pkg::in_item_t it;
    it.operation   = pzr_pkg::OP_WRITE;
    it.entry_index = idx;
    it.entry_color = col;
    it.data_byte   = 8'($urandom);
    it.last_byte   = 1'($urandom);
    return it;
  endfunction

  function automatic pzr_pkg::in_item_t data_item(logic [7:0] b, logic last);
    pzr_pkg::in_item_t it;
    it.operation   = pzr_pkg::OP_DATA;
    it.entry_index = 8'($urandom);
    it.entry_color = $urandom;
    it.data_byte   = b;
    it.last_byte   = last;
    return it;
  endfunction

  function automatic dir_row_t row_item(pzr_pkg::in_item_t it);
    dir_row_t r;
    r.kind  = ROW_ITEM;
    r.item  = it;
    r.typed = 1'b0;
    r.run   = '0;
    r.mode  = MODE_ZRUN;
    return r;
  endfunction

  function automatic dir_row_t row_run(logic [7:0] b, logic last, logic [31:0] col,
                                       logic [7:0] len, logic [15:0] st);
    dir_row_t r;
    r = row_item(data_item(b, last));
    r.typed = 1'b1;
    r.run.pixel_color    = col;
    r.run.run_length     = len;
    r.run.start_index    = st;
    r.run.end_of_image   = last;
    r.run.index_overflow = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t row_mode(logic m);
    dir_row_t r;
    r = row_item('0);
    r.kind = ROW_MODE;
    r.mode = m;
    return r;
  endfunction

  task automatic offer(pzr_pkg::in_item_t it, bit typed, pzr_pkg::out_item_t run);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    in_item   <= it;
    typed_due <= typed;
    typed_run <= run;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_data(logic [7:0] b, logic last);
    offer(data_item(b, last), 1'b0, '0);
  endtask

  task automatic send_write(logic [7:0] idx, logic [31:0] col);
    offer(write_item(idx, col), 1'b0, '0);
  endtask

  // stop offering until every expected run is out and the pipeline is quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic zrun_image();
    int len;
    len = $urandom_range(1, 24);
    repeat (len) begin
      case ($urandom_range(0, 19))
        0, 1: send_write(8'($urandom), rand_color());
        2, 3, 4, 5: begin
          send_data(8'h00, 1'b0);
          send_data(8'($urandom), ($urandom_range(0, 15) == 0));
        end
        // noise: any byte, sometimes ending the image early
        6: send_data(8'($urandom), 1'($urandom));
        default: send_data(8'($urandom_range(1, 255)), 1'b0);
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        send_data(8'h00, 1'b0);
        send_data(8'($urandom), 1'b1);
      end
      2: send_data(8'h00, 1'b1);
      default: send_data(8'($urandom_range(1, 255)), 1'b1);
    endcase
  endtask

  task automatic raw_image();
    int len;
    len = $urandom_range(1, 24);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) send_write(8'($urandom), rand_color());
      else send_data(8'($urandom), 1'($urandom_range(0, 19) == 0));
    end
    send_data(8'($urandom), 1'b1);
  endtask

  // one image long enough to reach the position limit exactly, then go past it
  task automatic long_image();
    int unsigned total;
    int unsigned cnt;
    total = 0;
    while (total + 255 <= pzr_pkg::MAX_PIXELS) begin
      if ($urandom_range(0, 7) == 0) begin
        send_data(8'($urandom_range(1, 255)), 1'b0);
        total++;
      end else begin
        cnt = $urandom_range(180, 255);
        send_data(8'h00, 1'b0);
        send_data(8'(cnt), 1'b0);
        total += cnt;
      end
    end
    if (total < pzr_pkg::MAX_PIXELS) begin
      send_data(8'h00, 1'b0);
      send_data(8'(pzr_pkg::MAX_PIXELS - total), 1'b0);
    end
    send_data(8'($urandom_range(1, 255)), 1'b0);
    send_data(8'h00, 1'b0);
    send_data(8'($urandom_range(1, 255)), 1'b0);
    send_data(8'($urandom_range(1, 255)), 1'b1);
  endtask

  initial begin
    int send_mix [3];
    int recv_mix [3];
    int mark;
    send_mix = '{15, 81, 0};
    recv_mix = '{81, 15, 0};

    rst_n       = 1'b0;
    push        = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = MODE_ZRUN;
    typed_due   = 1'b0;
    typed_run   = '0;
    hold_req    = 1'b0;
    zero_marker = 1'b0;
    pix_ovf     = 1'b0;
    pix_pos     = 0;
    zrun_mode   = MODE_ZRUN;
    send_idle   = send_mix[0];
    recv_idle   = recv_mix[0];

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole palette so no byte ever reads an unwritten entry
    for (int i = 0; i < 256; i++) send_write(8'(i), rand_color());

    dir_rows.push_back(row_item(write_item(8'd1, 32'h0011_2233)));
    dir_rows.push_back(row_item(write_item(8'd255, 32'hFFFF_FFFF)));
    dir_rows.push_back(row_item(write_item(8'd2, 32'h12FF_00FF)));
    dir_rows.push_back(row_item(write_item(8'd0, 32'h00FF_00FF)));
    dir_rows.push_back(row_item(write_item(8'd3, 32'h0000_0000)));
    dir_rows.push_back(row_run(8'd1, 1'b0, 32'hFF33_2211, 8'd1, 16'd0));
    dir_rows.push_back(row_run(8'd255, 1'b0, 32'hFFFF_FFFF, 8'd1, 16'd1));
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_run(8'd255, 1'b0, 32'h0, 8'd255, 16'd2));
    // zero count swallows the marker
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_run(8'd5, 1'b1, 32'h0, 8'd5, 16'd257));
    // zero as the final byte
    dir_rows.push_back(row_run(8'd0, 1'b1, 32'h0, 8'd1, 16'd0));
    // zero count as the final byte gives an empty end run
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_run(8'd0, 1'b1, 32'h0, 8'd0, 16'd0));
    dir_rows.push_back(row_run(8'd2, 1'b0, 32'hFFFF_00FF, 8'd1, 16'd0));
    // marker left pending across the switch to raw
    dir_rows.push_back(row_item(data_item(8'd0, 1'b0)));
    dir_rows.push_back(row_mode(MODE_RAW));
    dir_rows.push_back(row_run(8'd1, 1'b0, 32'hFF11_2233, 8'd1, 16'd1));
    dir_rows.push_back(row_run(8'd2, 1'b0, 32'h0, 8'd1, 16'd2));
    dir_rows.push_back(row_run(8'd0, 1'b0, 32'h0, 8'd1, 16'd3));
    dir_rows.push_back(row_run(8'd3, 1'b0, 32'hFF00_0000, 8'd1, 16'd4));
    dir_rows.push_back(row_run(8'd255, 1'b1, 32'hFFFF_FFFF, 8'd1, 16'd5));
    dir_rows.push_back(row_mode(MODE_ZRUN));
    dir_rows.push_back(row_run(8'd255, 1'b1, 32'hFFFF_FFFF, 8'd1, 16'd0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MODE) set_mode(dir_rows[i].mode);
      else offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].run);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = send_mix[ph];
      recv_idle = recv_mix[ph];
      if (ph == 2) begin
        set_mode(MODE_ZRUN);
        // receiver goes quiet while the sender keeps pushing
        hold_req = 1'b1;
        long_image();
      end
      mark = n_items;
      while (n_items - mark < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1: set_mode(1'($urandom));
          2: settle();
          default: ;
        endcase
        if (zrun_mode == MODE_ZRUN) zrun_image();
        else raw_image();
      end
    end

    set_mode(MODE_RAW);
    set_mode(MODE_ZRUN);
    settle();
    $display("%0d items in, %0d runs checked, %0d image ends, %0d runs with overflow",
             n_items, n_runs, n_eoi, n_ovf);
    $display("%0d mode writes over three idle mixes and a %0d-cycle output hold",
             n_mode_writes, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
